@@ sv/b64d_pkg.sv @@
`timescale 1ns / 1ps
// b64d_pkg: shared types, constants and the character classifier of the base64 stream decoder
// depends on nothing; used by every b64d module and the top level

package b64d_pkg;

  localparam int MaxOutputBytes = 1024;
  localparam int CountW         = 11;
  localparam int QDepth         = 4;
  localparam int QPtrW          = $clog2(QDepth);
  localparam int QCntW          = $clog2(QDepth + 1);

  localparam logic [7:0] PadChar = 8'h3d;
  localparam logic [7:0] EndChar = 8'h00;

  // result kind as seen on the output ports
  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindEnd   = 2'd1,
    KindError = 2'd2
  } kind_e;

  // command kind carried between front and back
  typedef enum logic [1:0] {
    CmdData,
    CmdEnd,
    CmdError
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [1:0]      nbytes;  // 1 to 3 for data commands
    logic [2:0][7:0] bytes;   // bytes[0] goes out first
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.value = 6'd62;
    end else if (c == 8'h2f) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ sv/base64_stream_decoder.sv @@
`timescale 1ns / 1ps
// base64_stream_decoder: top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_front, b64d_cmdq, b64d_back
//
// channel   direction  handshake           payload
// input     in         push / full         text_char_i (8)
// result    out        empty / pop         kind_o (2), data_byte_o (8),
//                                          last_of_run_o (1), total_bytes_o (11)
//
// one character is taken per cycle whenever the command queue has room; a result
// leaves per cycle while the result side pops, so a full group of four gives three byte results.
// the result rate of the back end (one per cycle) sets the limit: a long run of
// end or error characters at one per cycle, or three-byte groups, keep pace.
// the first result of a character passes the command queue, then the output register.
// reset clears group state, byte count, queue pointers and the output valid flag.
// a stalled result side fills the four-entry queue, then full rises.

module base64_stream_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    text_char_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    data_byte_o,
  output logic                          last_of_run_o,
  output logic [b64d_pkg::CountW-1:0]   total_bytes_o
);

  // front to queue
  logic           cmd_push;
  b64d_pkg::cmd_t cmd_wr;
  // queue to back
  b64d_pkg::cmd_t cmd_rd;
  logic           cmd_pop;
  logic           cmd_empty;
  logic           accept;

  // a transaction on the input side is taken only when the queue has room, so
  // every command the front emits always fits
  assign accept = push && !full;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_char_i (text_char_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wr)
  );

  b64d_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  // back end walks each data command byte by byte into the output register
  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_rd),
    .cmd_pop_o     (cmd_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .last_of_run_o (last_of_run_o),
    .total_bytes_o (total_bytes_o)
  );

endmodule

@@ sv/b64d_front.sv @@
`timescale 1ns / 1ps
// b64d_front: takes characters, tracks the group of four, builds one data command per group
// depends on b64d_pkg

module b64d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_char_i,
  output logic              cmd_push_o,
  output b64d_pkg::cmd_t    cmd_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] held_q, held_d;
  logic        tpad_q, tpad_d;

  b64d_pkg::sextet_t sx;
  logic              is_pad;
  logic [5:0]        s1, s2, s3, s_last;

  always_comb begin
    sx     = b64d_pkg::sextet_of(text_char_i);
    is_pad = (text_char_i == b64d_pkg::PadChar);
    s1     = held_q[17:12];
    s2     = held_q[11:6];
    s3     = held_q[5:0];
    s_last = is_pad ? 6'd0 : sx.value;

    pos_d       = pos_q;
    held_d      = held_q;
    tpad_d      = tpad_q;
    cmd_push_o  = 1'b0;
    cmd_o.kind  = b64d_pkg::CmdData;
    cmd_o.nbytes = 2'd3;
    cmd_o.bytes[0] = {s1, s2[5:4]};
    cmd_o.bytes[1] = {s2[3:0], s3[5:2]};
    cmd_o.bytes[2] = {s3[1:0], s_last};

    if (accept_i) begin
      priority if (pos_q == 2'd0 && text_char_i == b64d_pkg::EndChar) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = b64d_pkg::CmdEnd;
        held_d     = '0;
        tpad_d     = 1'b0;
      end else if (!sx.valid && !(is_pad && pos_q[1])) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = b64d_pkg::CmdError;
        pos_d      = 2'd0;
        held_d     = '0;
        tpad_d     = 1'b0;
      end else if (pos_q != 2'd3) begin
        held_d = {held_q[11:0], s_last};
        pos_d  = pos_q + 2'd1;
        if (pos_q == 2'd2) begin
          tpad_d = is_pad;
        end
      end else begin
        cmd_push_o = 1'b1;
        if (tpad_q) begin
          cmd_o.nbytes = 2'd1;
        end else if (is_pad) begin
          cmd_o.nbytes = 2'd2;
        end
        pos_d  = 2'd0;
        held_d = '0;
        tpad_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      held_q <= '0;
      tpad_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      held_q <= held_d;
      tpad_q <= tpad_d;
    end
  end

endmodule

@@ sv/b64d_cmdq.sv @@
`timescale 1ns / 1ps
// b64d_cmdq: small command queue between the front and the back
// depends on b64d_pkg

module b64d_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output b64d_pkg::cmd_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  b64d_pkg::cmd_t                 mem_q [b64d_pkg::QDepth];
  logic [b64d_pkg::QPtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [b64d_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == b64d_pkg::QCntW'(b64d_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    wr_d    = do_push ? wr_q + 1'b1 : wr_q;
    rd_d    = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d   = cnt_q + b64d_pkg::QCntW'(do_push) - b64d_pkg::QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= b64d_pkg::QCntW'(b64d_pkg::QDepth))
    else $error("command queue count beyond depth");

  a_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b64d_pkg::QPtrW'(wr_q - rd_q) == b64d_pkg::QPtrW'(cnt_q))
    else $error("command queue pointers disagree with count");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o)
    else $error("command queue left full without a pop");

endmodule

@@ sv/b64d_back.sv @@
`timescale 1ns / 1ps
// b64d_back: expands commands into results, keeps the byte count, holds the output register
// depends on b64d_pkg

module b64d_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_empty_i,
  input  b64d_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    data_byte_o,
  output logic                          last_of_run_o,
  output logic [b64d_pkg::CountW-1:0]   total_bytes_o
);

  localparam logic [b64d_pkg::CountW-1:0] CountMax =
    b64d_pkg::CountW'(b64d_pkg::MaxOutputBytes);

  logic                          ovalid_q, ovalid_d;
  logic [1:0]                    idx_q, idx_d;
  logic [b64d_pkg::CountW-1:0]   count_q, count_d, count_inc;
  b64d_pkg::kind_e               kind_q, kind_d;
  logic [7:0]                    byte_q, byte_d;
  logic                          last_q, last_d;
  logic [b64d_pkg::CountW-1:0]   total_q, total_d;
  logic                          load, is_last_byte;

  assign empty_o       = !ovalid_q;
  assign kind_o        = kind_q;
  assign data_byte_o   = byte_q;
  assign last_of_run_o = last_q;
  assign total_bytes_o = total_q;

  always_comb begin
    load         = !cmd_empty_i && (!ovalid_q || pop_i);
    count_inc    = (count_q < CountMax) ? count_q + 1'b1 : count_q;
    is_last_byte = (idx_q == cmd_i.nbytes - 2'd1);

    ovalid_d  = (ovalid_q && !pop_i) || load;
    idx_d     = idx_q;
    count_d   = count_q;
    kind_d    = kind_q;
    byte_d    = byte_q;
    last_d    = last_q;
    total_d   = total_q;
    cmd_pop_o = 1'b0;

    if (load) begin
      unique case (cmd_i.kind)
        b64d_pkg::CmdData: begin
          kind_d  = b64d_pkg::KindData;
          byte_d  = cmd_i.bytes[idx_q];
          last_d  = is_last_byte;
          count_d = count_inc;
          total_d = count_inc;
          if (is_last_byte) begin
            cmd_pop_o = 1'b1;
            idx_d     = 2'd0;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
        b64d_pkg::CmdEnd: begin
          kind_d    = b64d_pkg::KindEnd;
          byte_d    = 8'd0;
          last_d    = 1'b1;
          total_d   = count_q;
          count_d   = '0;
          cmd_pop_o = 1'b1;
        end
        default: begin
          kind_d    = b64d_pkg::KindError;
          byte_d    = 8'd0;
          last_d    = 1'b1;
          total_d   = '0;
          count_d   = '0;
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      idx_q    <= 2'd0;
      count_q  <= '0;
    end else begin
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    total_q <= total_d;
  end

  a_nondata_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && kind_q != b64d_pkg::KindData) |-> (byte_q == 8'd0 && last_q))
    else $error("end or error result with data or without last");

  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && kind_q == b64d_pkg::KindError) |-> (total_q == '0))
    else $error("error result with nonzero total");

  a_count_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("byte count past saturation");

endmodule

@@ dv/base64_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// base64_stream_decoder_tb: self-checking testbench for the streaming base64 decoder
// depends on b64d_pkg and the base64_stream_decoder rtl; needs no files or arguments

module base64_stream_decoder_tb;

  localparam int IdleMax       = 17;    // longest random per-transaction wait on either side
  localparam int HoldCycles    = 80;    // long result-side hold-off to fill the block
  localparam int WatchdogLimit = 2000;  // cycles without any transaction before giving up
  localparam int RandomChars   = 320;
  localparam int DrainCycles   = 10;

  // directed opening: pads in both places, extreme bit patterns, end, errors
  localparam logic [7:0] DirectedChars [26] = '{
    "T", "Q", b64d_pkg::PadChar, b64d_pkg::PadChar,  // pad in third place, one byte
    "T", "W", "E", b64d_pkg::PadChar,                // pad in fourth place, two bytes
    "T", "Q", b64d_pkg::PadChar, "A",                // third pad, fourth valid but ignored
    "A", "A", "A", "A",                              // all-zero bytes
    "/", "/", "/", "/",                              // all-ones bytes
    b64d_pkg::EndChar,                               // end of message with a nonzero count
    8'hff,                                           // byte above 127
    "Q", b64d_pkg::PadChar,                          // pad in second place
    "A", b64d_pkg::EndChar                           // zero inside a group
  };

  typedef enum int {
    GroupFull,      // four alphabet characters, three bytes
    GroupTwo,       // pad in fourth place
    GroupOne,       // pad in third and fourth place
    GroupOneTail    // pad in third place, ignored character in fourth
  } group_shape_e;

  typedef enum int {
    BreakBadChar,   // non-alphabet byte anywhere in a group
    BreakEarlyPad,  // pad in first or second place
    BreakMidZero    // zero after the first character of a group
  } break_kind_e;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [7:0]                  data;
    logic                        last;
    logic [b64d_pkg::CountW-1:0] total;
  } decode_result_t;

  // predicts decoder output per character and checks results in order
  class decode_scoreboard;
    decode_result_t              predicted_q[$];
    logic [1:0]                  group_idx;
    logic [17:0]                 held;
    logic                        pad_third;
    logic [b64d_pkg::CountW-1:0] msg_count;
    int                          failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      group_idx = '0;
      held      = '0;
      pad_third = 1'b0;
      msg_count = '0;
    endfunction

    // 6-bit value of an alphabet character, -1 otherwise
    function int sextet_value(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 'h41;       // A-Z
      if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 'h61 + 26;  // a-z
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;  // 0-9
      if (c == 8'h2b) return 62;
      if (c == 8'h2f) return 63;
      return -1;
    endfunction

    function void expect_result(input b64d_pkg::kind_e k, input logic [7:0] b,
                                input logic last, input logic [b64d_pkg::CountW-1:0] tot);
      decode_result_t r;
      r.kind  = k;
      r.data  = b;
      r.last  = last;
      r.total = tot;
      predicted_q.push_back(r);
    endfunction

    function void expect_byte(input logic [7:0] b, input logic last);
      if (msg_count < b64d_pkg::CountW'(b64d_pkg::MaxOutputBytes)) begin
        msg_count = msg_count + 1'b1;
      end
      expect_result(b64d_pkg::KindData, b, last, msg_count);
    endfunction

    function void note_char(input logic [7:0] c);
      int         idx;
      logic       is_pad;
      logic [5:0] s;
      int         nbytes;
      is_pad = (c == b64d_pkg::PadChar);
      idx    = sextet_value(c);
      if (group_idx == 2'd0 && c == b64d_pkg::EndChar) begin
        expect_result(b64d_pkg::KindEnd, 8'h00, 1'b1, msg_count);
        msg_count = '0;
        held      = '0;
        pad_third = 1'b0;
        return;
      end
      if (idx < 0 && !(is_pad && group_idx >= 2'd2)) begin
        expect_result(b64d_pkg::KindError, 8'h00, 1'b1, '0);
        restart();
        return;
      end
      s = is_pad ? 6'd0 : 6'(idx);
      if (group_idx != 2'd3) begin
        if (group_idx == 2'd2) pad_third = is_pad;
        held      = {held[11:0], s};
        group_idx = group_idx + 2'd1;
        return;
      end
      nbytes = pad_third ? 1 : (is_pad ? 2 : 3);
      expect_byte({held[17:12], held[11:10]}, nbytes == 1);
      if (nbytes >= 2) expect_byte({held[9:6], held[5:2]}, nbytes == 2);
      if (nbytes == 3) expect_byte({held[1:0], s}, 1'b1);
      group_idx = '0;
      held      = '0;
      pad_third = 1'b0;
    endfunction

    function void check_result(input decode_result_t got);
      decode_result_t want;
      if (predicted_q.size() == 0) begin
        if (failures < 10)
          $display("unexpected result: kind %0d byte %02h last %0b total %0d",
                   got.kind, got.data, got.last, got.total);
        failures++;
        return;
      end
      want = predicted_q.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.last !== want.last || got.total !== want.total) begin
        if (failures < 10)
          $display({"mismatch: expected kind %0d byte %02h last %0b total %0d,",
                    " got kind %0d byte %02h last %0b total %0d"},
                   want.kind, want.data, want.last, want.total,
                   got.kind, got.data, got.last, got.total);
        failures++;
      end
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        push        = 1'b0;
  logic [7:0]                  text_char_i = 8'h00;
  logic                        pop         = 1'b0;
  logic                        full;
  logic                        empty;
  logic [1:0]                  kind_o;
  logic [7:0]                  data_byte_o;
  logic                        last_of_run_o;
  logic [b64d_pkg::CountW-1:0] total_bytes_o;

  decode_scoreboard sb = new();

  // idling controls: steady modes turn off the random waits on one side
  bit tx_steady  = 1'b0;
  bit rx_steady  = 1'b0;
  bit hold_req   = 1'b0;  // asks the result side for one long hold-off
  int chars_sent = 0;
  int idle_cycles = 0;

  base64_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_char_i   (text_char_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .last_of_run_o (last_of_run_o),
    .total_bytes_o (total_bytes_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hang on either side shows up as a long run with no transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("base64_stream_decoder_tb failed");
        $finish;
      end
    end
  end

  // random character from the 64-symbol alphabet
  function automatic logic [7:0] alpha_char();
    int v;
    v = $urandom_range(0, 63);
    if (v < 26) return 8'h41 + 8'(v);       // A-Z
    if (v < 52) return 8'h61 + 8'(v - 26);  // a-z
    if (v < 62) return 8'h30 + 8'(v - 52);  // 0-9
    return (v == 62) ? 8'h2b : 8'h2f;       // + or /
  endfunction

  // one input transaction; entered and left at a falling edge
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, IdleMax);
    // push only drops when there is a gap, so it never toggles within one step
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    text_char_i <= c;
    do @(posedge clk_i); while (full);
    sb.note_char(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_group(input group_shape_e shape);
    send_char(alpha_char());
    send_char(alpha_char());
    case (shape)
      GroupFull: begin
        send_char(alpha_char());
        send_char(alpha_char());
      end
      GroupTwo: begin
        send_char(alpha_char());
        send_char(b64d_pkg::PadChar);
      end
      GroupOne: begin
        send_char(b64d_pkg::PadChar);
        send_char(b64d_pkg::PadChar);
      end
      default: begin
        send_char(b64d_pkg::PadChar);
        send_char(alpha_char());
      end
    endcase
  endtask

  // well-formed message body with random content, optionally closed by a zero
  task automatic send_message(input int groups, input bit full_only, input bit close_msg);
    repeat (groups) send_group(full_only ? GroupFull : group_shape_e'($urandom_range(0, 3)));
    if (close_msg) send_char(b64d_pkg::EndChar);
  endtask

  // partial group followed by a character that must raise an error
  task automatic send_broken();
    int         lead;
    logic [7:0] c;
    case (break_kind_e'($urandom_range(0, 2)))
      BreakBadChar: begin
        lead = $urandom_range(0, 3);
        do c = 8'($urandom_range(1, 255));
        while (sb.sextet_value(c) >= 0 || c == b64d_pkg::PadChar);
      end
      BreakEarlyPad: begin
        lead = $urandom_range(0, 1);
        c    = b64d_pkg::PadChar;
      end
      default: begin
        lead = $urandom_range(1, 3);
        c    = b64d_pkg::EndChar;
      end
    endcase
    repeat (lead) send_char(alpha_char());
    send_char(c);
  endtask

  // sender pause until every predicted result has been popped
  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // result side: random stalls, steady stretches and one long hold-off on request
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, IdleMax);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_result({kind_o, data_byte_o, last_of_run_o, total_bytes_o});
      @(negedge clk_i);
      if ($urandom_range(0, 31) == 0) rx_steady = ~rx_steady;
    end
  end

  initial begin : stimulus
    int random_goal;
    int roll;
    bit pressed;
    pressed = 1'b0;

    // reset held from the start, released away from the rising edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirectedChars[i]) send_char(DirectedChars[i]);
    drain_results();

    // random part: mostly well-formed messages, some broken groups and raw noise
    random_goal = chars_sent + RandomChars;
    while (chars_sent < random_goal) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      // once, about a third in: stall results long enough that full rises
      if (!pressed && chars_sent > random_goal - 2 * RandomChars / 3) begin
        pressed   = 1'b1;
        hold_req  = 1'b1;
        tx_steady = 1'b1;
        send_message(8, 1'b1, 1'b0);
        drain_results();
        tx_steady = 1'b0;
      end
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        send_message($urandom_range(1, 6), 1'b0, $urandom_range(0, 3) != 0);
      end else if (roll < 9) begin
        send_broken();
      end else begin
        send_char(8'($urandom_range(0, 255)));
      end
    end
    drain_results();

    // allow any stray result to surface before the verdict
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("base64_stream_decoder_tb passed");
    end else begin
      $display("base64_stream_decoder_tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_cmdq.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
dv/base64_stream_decoder_tb.sv
